### rtl/gosa_pkg.sv
// Shared types, widths and codes for the swizzled operand address generator.
package gosa_pkg;

    localparam int DEF_MAX_ROWS = 256;
    localparam int DEF_MAX_COLS = 256;

    localparam int CFG_W   = 9;
    localparam int EB_W    = 7;
    localparam int KF_W    = 2;
    localparam int IDX_W   = 2;
    localparam int ROW_W   = 8;
    localparam int COL_W   = 8;
    localparam int OFF_W   = 17;
    localparam int KIND_W  = 3;
    localparam int PITCH_W = CFG_W + 1;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 5;

    localparam logic [KIND_W-1:0] KIND_F64_CONG  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_F64_CROSS = 3'd1;
    localparam logic [KIND_W-1:0] KIND_F32_CONG  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PADDED    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_GENERAL   = 3'd4;

    localparam logic [IDX_W-1:0] REG_TILE_ROWS = 2'd0;
    localparam logic [IDX_W-1:0] REG_TILE_COLS = 2'd1;
    localparam logic [IDX_W-1:0] REG_ELEM_BITS = 2'd2;
    localparam logic [IDX_W-1:0] REG_K_FACTOR  = 2'd3;

    localparam logic [CFG_W-1:0] RST_TILE_ROWS = 9'd64;
    localparam logic [CFG_W-1:0] RST_TILE_COLS = 9'd64;
    localparam logic [EB_W-1:0]  RST_ELEM_BITS = 7'd16;
    localparam logic [KF_W-1:0]  RST_K_FACTOR  = 2'd1;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic               eb_ok;
        logic               k2;
        logic [1:0]         log_eb;
        logic [CFG_W-1:0]   rows;
        logic [CFG_W-1:0]   cols;
        logic [PITCH_W-1:0] pitch;
    } t_layout;

    typedef struct packed {
        logic [ROW_W-1:0]   mul_a;
        logic [PITCH_W-1:0] mul_b;
        logic [OFF_W-1:0]   addend;
        logic [KIND_W-1:0]  kind;
        logic               coord_err;
        logic               cfg_err;
    } t_opnd;

    typedef struct packed {
        logic [OFF_W-1:0]  product;
        logic [OFF_W-1:0]  addend;
        logic [KIND_W-1:0] kind;
        logic              coord_err;
        logic              cfg_err;
    } t_prod;

endpackage

### rtl/gemm_operand_smem_swizzle_address_core.sv
// Top level of the swizzled shared-memory operand address generator.
// Each input beat carries a (row, col) coordinate and yields one output beat, with the element
// offset, the chosen layout and two error flags. A new beat can be accepted in every cycle,
// the rate being set by the four-stage pipeline (input capture, operand formation, one 8x10-bit
// multiply, final add into the output register). Each stage moves on whenever the stage after it
// is empty or moving on, so the input is held off only when all four stages hold beats and the
// finished beat waits at the output. Configuration writes take effect at once and are to be made
// only while no beat is in flight.
module gemm_operand_smem_swizzle_address_core #(
    parameter int MAX_ROWS = gosa_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = gosa_pkg::DEF_MAX_COLS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [gosa_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // row, col
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [gosa_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // offset, zero fill
    output logic [gosa_pkg::OUT_USER_W-1:0]  m_axis_tuser,   // layout_kind, coord_error,
                                                             // config_error
    input  logic                             i_cfg_we,
    input  logic [gosa_pkg::IDX_W-1:0]       i_cfg_addr,
    input  logic [gosa_pkg::CFG_W-1:0]       i_cfg_wdata
);
    import gosa_pkg::*;

    t_layout           layout;
    t_opnd             opnd;
    logic              opnd_valid;
    logic              opnd_ready;
    logic [OFF_W-1:0]  offset;
    logic [KIND_W-1:0] kind;
    logic              coord_err;
    logic              cfg_err;

    gosa_cfg #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_layout    (layout)
    );

    gosa_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_row    (s_axis_tdata[ROW_W-1:0]),
        .i_col    (s_axis_tdata[ROW_W +: COL_W]),
        .i_layout (layout),
        .o_valid  (opnd_valid),
        .i_ready  (opnd_ready),
        .o_opnd   (opnd)
    );

    gosa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (opnd_valid),
        .o_ready     (opnd_ready),
        .i_opnd      (opnd),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_offset    (offset),
        .o_kind      (kind),
        .o_coord_err (coord_err),
        .o_cfg_err   (cfg_err)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - OFF_W){1'b0}}, offset};
    assign m_axis_tuser = {cfg_err, coord_err, kind};

endmodule

### rtl/gosa_cfg.sv
// Configuration registers and layout dispatch for the swizzled address generator.
module gosa_cfg #(
    parameter int MAX_ROWS = gosa_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = gosa_pkg::DEF_MAX_COLS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gosa_pkg::IDX_W-1:0]    i_cfg_addr,
    input  logic [gosa_pkg::CFG_W-1:0]    i_cfg_wdata,
    output gosa_pkg::t_layout             o_layout
);
    import gosa_pkg::*;

    logic [CFG_W-1:0]   r_tile_rows;
    logic [CFG_W-1:0]   r_tile_cols;
    logic [EB_W-1:0]    r_elem_bits;
    logic [KF_W-1:0]    r_k_factor;

    logic [CFG_W-1:0]   rows;
    logic [CFG_W-1:0]   cols;
    logic               eb_ok;
    logic               k2;
    logic [1:0]         lrel;
    logic [2:0]         sh_pad;
    logic [2:0]         sh_gen;
    logic [OFF_W-1:0]   pad_chk;
    logic [OFF_W-1:0]   gen_chk;
    logic               pad_ok;
    logic [PITCH_W-1:0] pitch;
    logic [KIND_W-1:0]  kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_rows <= RST_TILE_ROWS;
            r_tile_cols <= RST_TILE_COLS;
            r_elem_bits <= RST_ELEM_BITS;
            r_k_factor  <= RST_K_FACTOR;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_TILE_ROWS: r_tile_rows <= i_cfg_wdata;
                REG_TILE_COLS: r_tile_cols <= i_cfg_wdata;
                REG_ELEM_BITS: r_elem_bits <= i_cfg_wdata[EB_W-1:0];
                REG_K_FACTOR:  r_k_factor  <= i_cfg_wdata[KF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        rows = (int'(r_tile_rows) > MAX_ROWS) ? CFG_W'(MAX_ROWS) : r_tile_rows;
        cols = (int'(r_tile_cols) > MAX_COLS) ? CFG_W'(MAX_COLS) : r_tile_cols;
        eb_ok = (r_elem_bits == 7'd8) || (r_elem_bits == 7'd16) ||
                (r_elem_bits == 7'd32) || (r_elem_bits == 7'd64);
        case (r_elem_bits)
            7'd16:   lrel = 2'd1;
            7'd32:   lrel = 2'd2;
            7'd64:   lrel = 2'd3;
            default: lrel = 2'd0;
        endcase
        k2      = (r_k_factor == 2'd2);
        sh_pad  = {1'b0, lrel} + 3'd3;
        sh_gen  = sh_pad + {2'b00, k2};
        pad_chk = {8'b0, cols} << sh_pad;
        gen_chk = {8'b0, cols} << sh_gen;
        pad_ok  = eb_ok && (pad_chk[7:0] == 8'd0);
        pitch   = {1'b0, cols} + (pad_ok ? (PITCH_W'(16) >> lrel) : PITCH_W'(0));

        if (!eb_ok) begin
            kind = KIND_PADDED;
        end else if (lrel == 2'd3 && !k2 && cols[3:0] == 4'd0) begin
            kind = KIND_F64_CONG;
        end else if (lrel == 2'd3 && k2 && rows[3:0] == 4'd0 && cols[3:0] == 4'd0) begin
            kind = KIND_F64_CROSS;
        end else if (lrel == 2'd2 && !k2 && cols[4:0] == 5'd0) begin
            kind = KIND_F32_CONG;
        end else if (lrel == 2'd0 && !k2) begin
            kind = KIND_PADDED;
        end else if (gen_chk[9:0] == 10'd0) begin
            kind = KIND_GENERAL;
        end else begin
            kind = KIND_PADDED;
        end

        o_layout.kind   = kind;
        o_layout.eb_ok  = eb_ok;
        o_layout.k2     = k2;
        o_layout.log_eb = lrel;
        o_layout.rows   = rows;
        o_layout.cols   = cols;
        o_layout.pitch  = pitch;
    end

endmodule

### rtl/gosa_front.sv
// Input capture and operand formation stages of the swizzled address pipeline.
module gosa_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [gosa_pkg::ROW_W-1:0] i_row,
    input  logic [gosa_pkg::COL_W-1:0] i_col,
    input  gosa_pkg::t_layout          i_layout,
    output logic                       o_valid,
    input  logic                       i_ready,
    output gosa_pkg::t_opnd            o_opnd
);
    import gosa_pkg::*;

    logic             r_a_valid;
    logic [ROW_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic             r_b_valid;
    t_opnd            r_b_opnd;
    t_opnd            n_opnd;

    logic             ready_a;
    logic             ready_b;
    logic [2:0]       la;
    logic [COL_W-1:0] vc;
    logic [COL_W-1:0] lane_mask;
    logic [1:0]       pv;
    logic             pp;
    logic [OFF_W-1:0] grp;
    logic [OFF_W-1:0] gen_c;

    assign ready_b = !r_b_valid || i_ready;
    assign ready_a = !r_a_valid || ready_b;
    assign o_ready = ready_a;
    assign o_valid = r_b_valid;
    assign o_opnd  = r_b_opnd;

    always_comb begin
        la        = 3'd4 - {1'b0, i_layout.log_eb};
        vc        = r_col >> la;
        lane_mask = (COL_W'(1) << la) - COL_W'(1);
        if (i_layout.k2) begin
            pv  = vc[1:0] ^ r_row[2:1];
            pp  = r_row[0];
            grp = (OFF_W'(vc >> 2) << 3) | OFF_W'({pp, pv});
        end else begin
            pv  = vc[1:0] ^ r_row[1:0];
            pp  = vc[2] ^ r_row[2];
            grp = (OFF_W'(vc >> 3) << 3) | OFF_W'({pp, pv});
        end
        gen_c = (grp << la) | OFF_W'(r_col & lane_mask);

        n_opnd.kind      = i_layout.kind;
        n_opnd.cfg_err   = !i_layout.eb_ok;
        n_opnd.coord_err = ({1'b0, r_row} >= i_layout.rows) ||
                           ({1'b0, r_col} >= i_layout.cols);
        case (i_layout.kind)
            KIND_F64_CONG: begin
                n_opnd.mul_a  = {r_row[7:2], r_col[2:1]};
                n_opnd.mul_b  = {1'b0, i_layout.cols};
                n_opnd.addend = OFF_W'({r_col[7:4], r_col[0],
                                        r_col[2:1] ^ r_row[1:0], r_col[3]});
            end
            KIND_F64_CROSS: begin
                n_opnd.mul_a  = {r_col[7:2], r_row[2:1]};
                n_opnd.mul_b  = {1'b0, i_layout.rows};
                n_opnd.addend = OFF_W'({r_row[7:4], r_col[3] ^ r_row[0],
                                        r_col[1:0], r_row[3] ^ r_col[2]});
            end
            KIND_F32_CONG: begin
                n_opnd.mul_a  = r_row;
                n_opnd.mul_b  = {1'b0, i_layout.cols};
                n_opnd.addend = OFF_W'({r_col[7:5], r_col[4:3] ^ r_row[1:0],
                                        r_col[2:0]});
            end
            KIND_GENERAL: begin
                n_opnd.mul_a  = i_layout.k2 ? {r_row[7:1], 1'b0} : r_row;
                n_opnd.mul_b  = {1'b0, i_layout.cols};
                n_opnd.addend = gen_c;
            end
            default: begin
                n_opnd.mul_a  = r_row;
                n_opnd.mul_b  = i_layout.pitch;
                n_opnd.addend = OFF_W'(r_col);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (ready_a) begin
                r_a_valid <= i_valid;
            end
            if (ready_b) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a && i_valid) begin
            r_row <= i_row;
            r_col <= i_col;
        end
        if (ready_b && r_a_valid) begin
            r_b_opnd <= n_opnd;
        end
    end

endmodule

### rtl/gosa_back.sv
// Multiply and final add stages with the output register of the address pipeline.
module gosa_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  gosa_pkg::t_opnd             i_opnd,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [gosa_pkg::OFF_W-1:0]  o_offset,
    output logic [gosa_pkg::KIND_W-1:0] o_kind,
    output logic                        o_coord_err,
    output logic                        o_cfg_err
);
    import gosa_pkg::*;

    localparam int PROD_W = ROW_W + PITCH_W;

    logic              r_c_valid;
    t_prod             r_c;
    t_prod             n_c;
    logic              r_d_valid;
    logic [OFF_W-1:0]  r_offset;
    logic [KIND_W-1:0] r_kind;
    logic              r_coord_err;
    logic              r_cfg_err;
    logic [PROD_W-1:0] full_prod;
    logic              ready_c;
    logic              ready_d;

    assign ready_d     = !r_d_valid || i_ready;
    assign ready_c     = !r_c_valid || ready_d;
    assign o_ready     = ready_c;
    assign o_valid     = r_d_valid;
    assign o_offset    = r_offset;
    assign o_kind      = r_kind;
    assign o_coord_err = r_coord_err;
    assign o_cfg_err   = r_cfg_err;

    always_comb begin
        full_prod     = PROD_W'(i_opnd.mul_a) * PROD_W'(i_opnd.mul_b);
        n_c.product   = full_prod[OFF_W-1:0];
        n_c.addend    = i_opnd.addend;
        n_c.kind      = i_opnd.kind;
        n_c.coord_err = i_opnd.coord_err;
        n_c.cfg_err   = i_opnd.cfg_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (ready_c) begin
                r_c_valid <= i_valid;
            end
            if (ready_d) begin
                r_d_valid <= r_c_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_c && i_valid) begin
            r_c <= n_c;
        end
        if (ready_d && r_c_valid) begin
            r_offset    <= r_c.product + r_c.addend;
            r_kind      <= r_c.kind;
            r_coord_err <= r_c.coord_err;
            r_cfg_err   <= r_c.cfg_err;
        end
    end

endmodule

### rtl/gosa_checker.sv
// Port-level checker for the swizzled address generator and its bind statement.
module gosa_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [gosa_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [gosa_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input logic [gosa_pkg::OUT_USER_W-1:0]  m_axis_tuser,
    input logic                             i_cfg_we,
    input logic [gosa_pkg::IDX_W-1:0]       i_cfg_addr,
    input logic [gosa_pkg::CFG_W-1:0]       i_cfg_wdata
);
    import gosa_pkg::*;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output beat valid straight after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output beat changed");

    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input held off while the output is empty");

    a_bad_width_padded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[4] |-> m_axis_tuser[2:0] == KIND_PADDED)
        else $error("bad element width reported with a swizzled layout");

endmodule

bind gemm_operand_smem_swizzle_address_core gosa_checker u_gosa_checker (.*);

### test/gemm_operand_smem_swizzle_address_core_test.sv
// Self-checking testbench for the swizzled shared-memory operand address generator.
`timescale 1ns / 100ps

module gemm_operand_smem_swizzle_address_core_test;

    import gosa_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_PHASES  = 14;
    localparam int PHASE_BEATS    = 107;
    localparam int DIRECTED_BEATS = 25;

    typedef struct packed {
        logic [OFF_W-1:0]  offset;
        logic [KIND_W-1:0] kind;
        logic              coord_err;
        logic              cfg_err;
    } t_addr_result;

    typedef struct packed {
        logic         load;
        logic [8:0]   rows;
        logic [8:0]   cols;
        logic [8:0]   eb;
        logic [8:0]   kf;
        logic [7:0]   row;
        logic [7:0]   col;
        logic         typed;
        t_addr_result want;
    } t_directed_beat;

    localparam t_addr_result UNTYPED = '0;

    localparam t_directed_beat DIRECTED [DIRECTED_BEATS] = '{
        '{1'b0, 9'd64, 9'd64, 9'd16, 9'd1, 8'd0, 8'd0, 1'b1,
          '{17'd0, KIND_GENERAL, 1'b0, 1'b0}},
        '{1'b0, 9'd64, 9'd64, 9'd16, 9'd1, 8'd255, 8'd255, 1'b1,
          '{17'd16519, KIND_GENERAL, 1'b1, 1'b0}},
        '{1'b0, 9'd64, 9'd64, 9'd16, 9'd1, 8'd63, 8'd63, 1'b0, UNTYPED},
        '{1'b1, 9'd32, 9'd32, 9'd64, 9'd1, 8'd0, 8'd0, 1'b1,
          '{17'd0, KIND_F64_CONG, 1'b0, 1'b0}},
        '{1'b0, 9'd32, 9'd32, 9'd64, 9'd1, 8'd5, 8'd17, 1'b0, UNTYPED},
        '{1'b0, 9'd32, 9'd32, 9'd64, 9'd1, 8'd255, 8'd0, 1'b0, UNTYPED},
        '{1'b1, 9'd32, 9'd32, 9'd64, 9'd2, 8'd3, 8'd9, 1'b0, UNTYPED},
        '{1'b0, 9'd32, 9'd32, 9'd64, 9'd2, 8'd31, 8'd31, 1'b0, UNTYPED},
        '{1'b1, 9'd16, 9'd64, 9'd32, 9'd1, 8'd2, 8'd37, 1'b0, UNTYPED},
        '{1'b0, 9'd16, 9'd64, 9'd32, 9'd1, 8'd15, 8'd63, 1'b0, UNTYPED},
        '{1'b1, 9'd16, 9'd32, 9'd8, 9'd1, 8'd1, 8'd0, 1'b1,
          '{17'd48, KIND_PADDED, 1'b0, 1'b0}},
        '{1'b0, 9'd16, 9'd32, 9'd8, 9'd1, 8'd3, 8'd5, 1'b0, UNTYPED},
        '{1'b1, 9'd64, 9'd64, 9'd16, 9'd2, 8'd0, 8'd0, 1'b1,
          '{17'd0, KIND_GENERAL, 1'b0, 1'b0}},
        '{1'b0, 9'd64, 9'd64, 9'd16, 9'd2, 8'd7, 8'd13, 1'b0, UNTYPED},
        '{1'b1, 9'd20, 9'd20, 9'd16, 9'd1, 8'd2, 8'd3, 1'b1,
          '{17'd43, KIND_PADDED, 1'b0, 1'b0}},
        '{1'b1, 9'd10, 9'd10, 9'd12, 9'd1, 8'd4, 8'd5, 1'b1,
          '{17'd45, KIND_PADDED, 1'b0, 1'b1}},
        '{1'b1, 9'd10, 9'd10, 9'd0, 9'd1, 8'd1, 8'd1, 1'b1,
          '{17'd11, KIND_PADDED, 1'b0, 1'b1}},
        '{1'b1, 9'd10, 9'd10, 9'h1FF, 9'd1, 8'd0, 8'd9, 1'b1,
          '{17'd9, KIND_PADDED, 1'b0, 1'b1}},
        '{1'b1, 9'd511, 9'd511, 9'd8, 9'd1, 8'd255, 8'd255, 1'b1,
          '{17'd69615, KIND_PADDED, 1'b0, 1'b0}},
        '{1'b0, 9'd511, 9'd511, 9'd8, 9'd1, 8'd0, 8'd0, 1'b1,
          '{17'd0, KIND_PADDED, 1'b0, 1'b0}},
        '{1'b1, 9'd0, 9'd0, 9'd16, 9'd1, 8'd0, 8'd0, 1'b1,
          '{17'd0, KIND_GENERAL, 1'b1, 1'b0}},
        '{1'b0, 9'd0, 9'd0, 9'd16, 9'd1, 8'd200, 8'd100, 1'b0, UNTYPED},
        '{1'b1, 9'd32, 9'd32, 9'd64, 9'd3, 8'd1, 8'd2, 1'b0, UNTYPED},
        '{1'b1, 9'd32, 9'd32, 9'd32, 9'd0, 8'd5, 8'd7, 1'b0, UNTYPED},
        '{1'b1, 9'd20, 9'd32, 9'd64, 9'd2, 8'd9, 8'd30, 1'b0, UNTYPED}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  i_cfg_we = 1'b0;
    logic [IDX_W-1:0]      i_cfg_addr = REG_TILE_ROWS;
    logic [CFG_W-1:0]      i_cfg_wdata = '0;

    logic [CFG_W-1:0] cfg_rows = RST_TILE_ROWS;
    logic [CFG_W-1:0] cfg_cols = RST_TILE_COLS;
    logic [EB_W-1:0]  cfg_eb   = RST_ELEM_BITS;
    logic [KF_W-1:0]  cfg_k    = RST_K_FACTOR;

    t_addr_result pending_addrs [$];
    int           mismatch_count = 0;
    int           beats_sent = 0;
    int           settings_loaded = 0;
    int           kind_tally [5] = '{0, 0, 0, 0, 0};
    int           coord_err_tally = 0;
    int           cfg_err_tally = 0;
    int           stall_cycles = 0;
    logic         quiet = 1'b0;

    gemm_operand_smem_swizzle_address_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_addr_result predict_address(input logic [7:0] row,
                                                     input logic [7:0] col);
        int unsigned i, j, rows, cols, eb, k, off, pitch;
        int unsigned tc, ts, c, s, rw, bank, kg, pair, x;
        int unsigned ae, t0, t1, vc, vs, tci, tcr, tsr, pv, pp;
        logic        eb_ok;
        t_addr_result r;
        i = 32'(row);
        j = 32'(col);
        rows = (32'(cfg_rows) > DEF_MAX_ROWS) ? DEF_MAX_ROWS : 32'(cfg_rows);
        cols = (32'(cfg_cols) > DEF_MAX_COLS) ? DEF_MAX_COLS : 32'(cfg_cols);
        eb = 32'(cfg_eb);
        k = (cfg_k == 2'd2) ? 2 : 1;
        eb_ok = (eb == 8) || (eb == 16) || (eb == 32) || (eb == 64);
        if (!eb_ok) begin
            r.kind = KIND_PADDED;
            off = i * cols + j;
        end else if (eb == 64 && k == 1 && cols % 16 == 0) begin
            r.kind = KIND_F64_CONG;
            tc = j / 16;
            ts = i / 4;
            c = j % 16;
            s = i % 4;
            rw = (c / 2) % 4;
            bank = (c % 2) * 8 + (rw ^ s) * 2 + c / 8;
            off = tc * 16 + bank + (ts * 4 + rw) * cols;
        end else if (eb == 64 && k == 2 && rows % 16 == 0 && cols % 16 == 0) begin
            r.kind = KIND_F64_CROSS;
            tc = j / 16;
            ts = i / 16;
            c = j % 16;
            s = i % 16;
            kg = c / 4;
            pair = s / 2;
            rw = pair % 4;
            bank = (((kg >> 1) ^ (s & 1)) & 1) * 8 + (c % 4) * 2 +
                   (((pair >> 2) ^ (kg & 1)) & 1);
            off = (kg * 4 + rw + tc * 16) * rows + ts * 16 + bank;
        end else if (eb == 32 && k == 1 && cols % 32 == 0) begin
            r.kind = KIND_F32_CONG;
            tc = j / 32;
            ts = i / 4;
            c = (j % 32) / 4;
            s = i % 4;
            x = (c & 1) | ((((c >> 1) ^ s) & 3) << 1);
            off = x * 4 + s * cols + tc * 32 + ts * cols * 4 + j % 4;
        end else if ((eb == 8 && k == 1) || (cols * eb * k) % 1024 != 0) begin
            r.kind = KIND_PADDED;
            pitch = cols;
            if ((eb * cols) % 256 == 0)
                pitch = pitch + 128 / eb;
            off = i * pitch + j;
        end else begin
            r.kind = KIND_GENERAL;
            ae = 128 / eb;
            t0 = 8 / k;
            t1 = (t0 > 4) ? t0 : 4;
            vc = j / ae;
            vs = i / k;
            tci = vc / t1;
            tcr = vc % t1 + (i % k) * t1;
            tsr = vs % t0;
            pv = (tcr % 4) ^ (tsr % 4);
            pp = ((tcr / 4) ^ (tsr / 4)) & 1;
            off = vs * cols * k + (pv + tci * t1 * k + pp * 4) * ae + j % ae;
        end
        r.offset = off[OFF_W-1:0];
        r.coord_err = (i >= rows) || (j >= cols);
        r.cfg_err = !eb_ok;
        return r;
    endfunction

    function automatic void pick_tile_config(input int scenario, output logic [8:0] rows,
                                             output logic [8:0] cols, output logic [8:0] eb,
                                             output logic [8:0] kf);
        int unsigned step;
        rows = 9'($urandom_range(1, 256));
        kf = 9'd1;
        case (scenario)
            0: begin
                eb = 9'd64;
                cols = 9'(16 * $urandom_range(1, 16));
            end
            1: begin
                eb = 9'd64;
                kf = 9'd2;
                rows = 9'(16 * $urandom_range(1, 16));
                cols = 9'(16 * $urandom_range(1, 16));
            end
            2: begin
                eb = 9'd32;
                cols = 9'(32 * $urandom_range(1, 8));
            end
            3: begin
                eb = 9'd8;
                cols = 9'($urandom_range(1, 256));
            end
            4: begin
                eb = 9'd16 << $urandom_range(0, 2);
                kf = 9'($urandom_range(1, 2));
                step = 1024 / (32'(eb) * 32'(kf));
                cols = 9'(step * $urandom_range(1, 256 / step));
            end
            5: begin
                eb = 9'd16 << $urandom_range(0, 1);
                kf = 9'($urandom_range(1, 2));
                cols = 9'($urandom_range(1, 256));
            end
            default: begin
                rows = 9'($urandom_range(0, 511));
                cols = 9'($urandom_range(0, 511));
                eb = 9'($urandom_range(0, 511));
                kf = 9'($urandom_range(0, 511));
            end
        endcase
    endfunction

    task automatic drain_pending();
        s_axis_tvalid <= 1'b0;
        while (pending_addrs.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic load_tile_config(input logic [8:0] rows, input logic [8:0] cols,
                                    input logic [8:0] eb, input logic [8:0] kf);
        logic [IDX_W-1:0] idx [4];
        logic [8:0]       vals [4];
        int               n;
        idx = '{REG_TILE_ROWS, REG_TILE_COLS, REG_ELEM_BITS, REG_K_FACTOR};
        vals = '{rows, cols, eb, kf};
        for (n = 0; n < 4; n++) begin
            i_cfg_we <= 1'b1;
            i_cfg_addr <= idx[n];
            i_cfg_wdata <= vals[n];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cfg_rows = rows;
        cfg_cols = cols;
        cfg_eb = eb[EB_W-1:0];
        cfg_k = kf[KF_W-1:0];
        settings_loaded++;
    endtask

    task automatic send_coord(input logic [7:0] row, input logic [7:0] col,
                              input t_addr_result want);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {col, row};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        pending_addrs = {pending_addrs, want};
        beats_sent++;
    endtask

    initial begin
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (!quiet && $urandom_range(0, 6) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_addr_result got;
        t_addr_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tdata[OFF_W-1:0], m_axis_tuser[KIND_W-1:0],
                    m_axis_tuser[KIND_W], m_axis_tuser[KIND_W+1]};
            if (got.kind < 5)
                kind_tally[got.kind]++;
            coord_err_tally += got.coord_err;
            cfg_err_tally += got.cfg_err;
            if (pending_addrs.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected beat offset=%0d kind=%0d coord=%0b cfg=%0b",
                             $realtime, got.offset, got.kind, got.coord_err, got.cfg_err);
            end else begin
                want = pending_addrs.pop_front();
                if (got.offset !== want.offset || got.kind !== want.kind ||
                    got.coord_err !== want.coord_err || got.cfg_err !== want.cfg_err) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"%0t: mismatch offset %0d/%0d kind %0d/%0d ",
                                  "coord %0b/%0b cfg %0b/%0b (expected/actual)"},
                                 $realtime, want.offset, got.offset, want.kind, got.kind,
                                 want.coord_err, got.coord_err, want.cfg_err, got.cfg_err);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("gemm_operand_smem_swizzle_address_core_test: done, errors");
            $finish;
        end
    end

    initial begin
        logic [8:0] rows, cols, eb, kf;
        logic [7:0] row, col;
        int         phase, scenario, eff_rows, eff_cols, n;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[d]) begin
            if (DIRECTED[d].load) begin
                drain_pending();
                load_tile_config(DIRECTED[d].rows, DIRECTED[d].cols, DIRECTED[d].eb,
                                 DIRECTED[d].kf);
            end
            send_coord(DIRECTED[d].row, DIRECTED[d].col,
                       DIRECTED[d].typed ? DIRECTED[d].want :
                                           predict_address(DIRECTED[d].row, DIRECTED[d].col));
        end

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_pending();
            if (phase == 0) begin
                rows = 9'd256;
                cols = 9'd256;
                eb = 9'd64;
                kf = 9'd1;
            end else if (phase == 1) begin
                rows = 9'd1;
                cols = 9'd1;
                eb = 9'd8;
                kf = 9'd1;
            end else begin
                scenario = (phase < 9) ? phase - 2 : int'($urandom_range(0, 6));
                pick_tile_config(scenario, rows, cols, eb, kf);
            end
            load_tile_config(rows, cols, eb, kf);
            if (phase == RANDOM_PHASES - 1)
                quiet = 1'b1;
            eff_rows = (32'(cfg_rows) > DEF_MAX_ROWS) ? DEF_MAX_ROWS : 32'(cfg_rows);
            eff_cols = (32'(cfg_cols) > DEF_MAX_COLS) ? DEF_MAX_COLS : 32'(cfg_cols);
            for (n = 0; n < PHASE_BEATS; n++) begin
                if (eff_rows != 0 && eff_cols != 0 && $urandom_range(0, 3) != 0) begin
                    row = 8'($urandom_range(0, eff_rows - 1));
                    col = 8'($urandom_range(0, eff_cols - 1));
                end else begin
                    row = 8'($urandom_range(0, 255));
                    col = 8'($urandom_range(0, 255));
                end
                send_coord(row, col, predict_address(row, col));
            end
        end

        drain_pending();
        repeat (8) @(posedge i_clk);
        $display("Sent %0d coordinates under %0d tile settings.", beats_sent, settings_loaded);
        $display("Layouts 0..4 seen %0d/%0d/%0d/%0d/%0d; coordinate flags %0d, width flags %0d.",
                 kind_tally[0], kind_tally[1], kind_tally[2], kind_tally[3], kind_tally[4],
                 coord_err_tally, cfg_err_tally);
        if (mismatch_count == 0 && pending_addrs.size() == 0) begin
            $display("gemm_operand_smem_swizzle_address_core_test: done, clean");
        end else begin
            $display("%0d mismatches, %0d beats outstanding.", mismatch_count,
                     pending_addrs.size());
            $display("gemm_operand_smem_swizzle_address_core_test: done, errors");
        end
        $finish;
    end

endmodule

### gemm_operand_smem_swizzle_address_core.f
rtl/gosa_pkg.sv
rtl/gosa_cfg.sv
rtl/gosa_front.sv
rtl/gosa_back.sv
rtl/gemm_operand_smem_swizzle_address_core.sv
rtl/gosa_checker.sv
test/gemm_operand_smem_swizzle_address_core_test.sv
